FILE: hw/rtl/pid_position_controller_defines.svh
// ----------------------------------------------------------------------------
// PID position controller: assertion macros
// Shared assertion shorthands, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_CONTROLLER_DEFINES_SVH
`define PID_POSITION_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define PIDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PIDC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Field widths, register indexes, configuration and stage types.
// ----------------------------------------------------------------------------
package pidc_pkg;

	localparam int SampleW = 16;              // setpoint, measurement, limits
	localparam int ErrW    = SampleW + 1;     // setpoint - measurement
	localparam int DriveW  = SampleW + 1;     // measurement + effort
	localparam int CoefW   = 16;              // gains and decay
	localparam int FracW   = 8;               // fraction bits of the terms
	localparam int PropW   = CoefW + ErrW;    // Q.8 proportional term
	localparam int IntegW  = SampleW + FracW; // clamped integral, Q.8
	localparam int DerivW  = 32;              // saturated filter state, Q.8
	localparam int DecayFrac = 15;            // Q1.15 decay
	localparam int CfgIdxW = 4;

	// register indexes
	localparam logic [CfgIdxW-1:0] RegPropGain  = 4'd0;
	localparam logic [CfgIdxW-1:0] RegIntegHalf = 4'd1;
	localparam logic [CfgIdxW-1:0] RegDerivGain = 4'd2;
	localparam logic [CfgIdxW-1:0] RegDerivDec  = 4'd3;
	localparam logic [CfgIdxW-1:0] RegIntegMin  = 4'd4;
	localparam logic [CfgIdxW-1:0] RegIntegMax  = 4'd5;
	localparam logic [CfgIdxW-1:0] RegEffortMin = 4'd6;
	localparam logic [CfgIdxW-1:0] RegEffortMax = 4'd7;

	// reset values
	localparam logic signed [CoefW-1:0]   PropGainRst = 16'sd256;
	localparam logic signed [SampleW-1:0] LimMinRst   = -16'sd32768;
	localparam logic signed [SampleW-1:0] LimMaxRst   = 16'sd32767;

	// derivative saturation bounds
	localparam logic signed [DerivW-1:0] DerivMax = 32'sh7fff_ffff;
	localparam logic signed [DerivW-1:0] DerivMin = 32'sh8000_0000;

	typedef struct packed {
		logic signed [CoefW-1:0]   prop_gain;
		logic signed [CoefW-1:0]   integral_half_gain;
		logic signed [CoefW-1:0]   deriv_gain;
		logic signed [CoefW-1:0]   deriv_decay;
		logic signed [SampleW-1:0] integral_min;
		logic signed [SampleW-1:0] integral_max;
		logic signed [SampleW-1:0] effort_min;
		logic signed [SampleW-1:0] effort_max;
	} pidc_cfg_t;

	// first-stage terms handed to the output stage
	typedef struct packed {
		logic signed [PropW-1:0]   prop;
		logic signed [IntegW-1:0]  integ;
		logic signed [DerivW-1:0]  deriv;
		logic signed [SampleW-1:0] meas;
	} pidc_terms_t;

endpackage

FILE: hw/rtl/pidc_in_if.sv
// ----------------------------------------------------------------------------
// PID controller sample channel
// Setpoint and measurement with valid/ready.
// ----------------------------------------------------------------------------
interface pidc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [pidc_pkg::SampleW-1:0]   setpoint;
	logic signed [pidc_pkg::SampleW-1:0]   measurement;

	modport source (output valid, output setpoint, output measurement, input ready);
	modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

FILE: hw/rtl/pidc_out_if.sv
// ----------------------------------------------------------------------------
// PID controller result channel
// Drive position and control effort with valid/ready.
// ----------------------------------------------------------------------------
interface pidc_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [pidc_pkg::DriveW-1:0]    drive_position;
	logic signed [pidc_pkg::SampleW-1:0]   control_effort;

	modport source (output valid, output drive_position, output control_effort, input ready);
	modport sink   (input valid, input drive_position, input control_effort, output ready);
endinterface

FILE: hw/rtl/pidc_cfg_if.sv
// ----------------------------------------------------------------------------
// PID controller configuration channel
// Register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface pidc_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [pidc_pkg::CfgIdxW-1:0]          index;
	logic [pidc_pkg::CoefW-1:0]            data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/pidc_core.sv
// ----------------------------------------------------------------------------
// PID controller first stage
// Error, proportional term, clamped trapezoidal integral and filtered
// derivative; holds the loop state and the stage-one terms.
// ----------------------------------------------------------------------------
module pidc_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic signed [pidc_pkg::SampleW-1:0] setpoint,
	input  logic signed [pidc_pkg::SampleW-1:0] measurement,
	input  pidc_pkg::pidc_cfg_t                 cfg,
	output pidc_pkg::pidc_terms_t               terms
);

	localparam int EsumW = pidc_pkg::ErrW + 1;
	localparam int ImulW = pidc_pkg::CoefW + EsumW;
	localparam int IrawW = ImulW + 1;
	localparam int DmW   = pidc_pkg::SampleW + 1;
	localparam int DgW   = pidc_pkg::CoefW + DmW;
	localparam int DecW  = pidc_pkg::CoefW + pidc_pkg::DerivW;
	localparam int RndW  = DecW - pidc_pkg::DecayFrac;
	localparam int DsumW = DgW + 2;

	// loop state
	logic signed [pidc_pkg::IntegW-1:0]  integral_sum_q;
	logic signed [pidc_pkg::ErrW-1:0]    last_error_q;
	logic signed [pidc_pkg::DerivW-1:0]  filt_deriv_q;
	logic signed [pidc_pkg::SampleW-1:0] last_meas_q;
	logic signed [pidc_pkg::PropW-1:0]   prop_s1;

	logic signed [pidc_pkg::ErrW-1:0]    err;
	logic signed [pidc_pkg::PropW-1:0]   prop;
	logic signed [EsumW-1:0]             esum;
	logic signed [ImulW-1:0]             imul;
	logic signed [IrawW-1:0]             iraw, ihi, ilo, ihi_cl, icl;
	logic signed [DmW-1:0]               dmeas;
	logic signed [DgW-1:0]               dg;
	logic signed [DecW-1:0]              dec_prod;
	logic signed [RndW-1:0]              dec_rnd;
	logic signed [DsumW-1:0]             dsum;
	logic signed [pidc_pkg::DerivW-1:0]  deriv_nxt;

	// error and proportional term
	always_comb begin
		err  = pidc_pkg::ErrW'(setpoint) - pidc_pkg::ErrW'(measurement);
		prop = pidc_pkg::PropW'(cfg.prop_gain) * pidc_pkg::PropW'(err);
	end

	// trapezoidal integral, upper limit first, then lower
	always_comb begin
		esum   = EsumW'(err) + EsumW'(last_error_q);
		imul   = ImulW'(cfg.integral_half_gain) * ImulW'(esum);
		iraw   = IrawW'(integral_sum_q) + IrawW'(imul);
		ihi    = IrawW'($signed({cfg.integral_max, {pidc_pkg::FracW{1'b0}}}));
		ilo    = IrawW'($signed({cfg.integral_min, {pidc_pkg::FracW{1'b0}}}));
		ihi_cl = (iraw > ihi) ? ihi : iraw;
		icl    = (ihi_cl < ilo) ? ilo : ihi_cl;
	end

	// derivative on measurement, low-passed, saturated to 32 bits
	always_comb begin
		dmeas    = DmW'(measurement) - DmW'(last_meas_q);
		dg       = DgW'(cfg.deriv_gain) * DgW'(dmeas);
		dec_prod = DecW'(cfg.deriv_decay) * DecW'(filt_deriv_q);
		dec_rnd  = RndW'((dec_prod + (DecW'(1) <<< (pidc_pkg::DecayFrac - 1)))
			>>> pidc_pkg::DecayFrac);
		dsum     = DsumW'(dec_rnd) - DsumW'(dg);
		if (dsum > DsumW'(pidc_pkg::DerivMax)) begin
			deriv_nxt = pidc_pkg::DerivMax;
		end else if (dsum < DsumW'(pidc_pkg::DerivMin)) begin
			deriv_nxt = pidc_pkg::DerivMin;
		end else begin
			deriv_nxt = pidc_pkg::DerivW'(dsum);
		end
	end

	// state update on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_sum_q <= '0;
			last_error_q   <= '0;
			filt_deriv_q   <= '0;
			last_meas_q    <= '0;
		end else if (en) begin
			integral_sum_q <= pidc_pkg::IntegW'(icl);
			last_error_q   <= err;
			filt_deriv_q   <= deriv_nxt;
			last_meas_q    <= measurement;
		end
	end

	// stage payload, no reset needed
	always_ff @(posedge clk) begin
		if (en) begin
			prop_s1 <= prop;
		end
	end

	assign terms.prop  = prop_s1;
	assign terms.integ = integral_sum_q;
	assign terms.deriv = filt_deriv_q;
	assign terms.meas  = last_meas_q;

endmodule

FILE: hw/rtl/pid_position_controller.sv
// ----------------------------------------------------------------------------
// PID position controller
// Discrete PID with clamped trapezoidal integral and low-passed derivative
// on the measurement; returns clamped effort and measurement plus effort.
// ----------------------------------------------------------------------------
//
//   port  dir   contents                          transaction
//   req   sink  setpoint, measurement             valid & ready
//   rsp   src   drive_position, control_effort    valid & ready
//   cfg   sink  index, data (register write)      valid & ready
//
// Two stages: the first forms all terms and updates the loop state, the
// second sums, rounds, clamps and holds the result in the output register.
// One transaction per cycle sustained while the output is not stalled.
// Reset clears configuration to defaults and all loop state at once.
// A stalled output holds its result; the first stage still fills behind it.
// Configuration is always ready; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`include "pid_position_controller_defines.svh"

module pid_position_controller (
	input  logic       clk,
	input  logic       arst_n,
	pidc_in_if.sink    req,
	pidc_out_if.source rsp,
	pidc_cfg_if.sink   cfg
);

	localparam int SumW = pidc_pkg::PropW + 2;
	localparam int EffW = SumW - pidc_pkg::FracW;

	pidc_pkg::pidc_cfg_t   cfg_q;
	pidc_pkg::pidc_terms_t terms;

	logic                                 valid_s1;
	logic                                 out_valid_q;
	logic signed [pidc_pkg::SampleW-1:0]  effort_q;
	logic signed [pidc_pkg::DriveW-1:0]   drive_q;
	logic                                 adv_s2;
	logic                                 accept;

	logic signed [SumW-1:0]               sum;
	logic signed [EffW-1:0]               eff_full, eff_hi;
	logic signed [pidc_pkg::SampleW-1:0]  effort;

	// configuration bank
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain          <= pidc_pkg::PropGainRst;
			cfg_q.integral_half_gain <= '0;
			cfg_q.deriv_gain         <= '0;
			cfg_q.deriv_decay        <= '0;
			cfg_q.integral_min       <= pidc_pkg::LimMinRst;
			cfg_q.integral_max       <= pidc_pkg::LimMaxRst;
			cfg_q.effort_min         <= pidc_pkg::LimMinRst;
			cfg_q.effort_max         <= pidc_pkg::LimMaxRst;
		end else if (cfg.valid) begin
			case (cfg.index)
				pidc_pkg::RegPropGain:  cfg_q.prop_gain          <= $signed(cfg.data);
				pidc_pkg::RegIntegHalf: cfg_q.integral_half_gain <= $signed(cfg.data);
				pidc_pkg::RegDerivGain: cfg_q.deriv_gain         <= $signed(cfg.data);
				pidc_pkg::RegDerivDec:  cfg_q.deriv_decay        <= $signed(cfg.data);
				pidc_pkg::RegIntegMin:  cfg_q.integral_min       <= $signed(cfg.data);
				pidc_pkg::RegIntegMax:  cfg_q.integral_max       <= $signed(cfg.data);
				pidc_pkg::RegEffortMin: cfg_q.effort_min         <= $signed(cfg.data);
				pidc_pkg::RegEffortMax: cfg_q.effort_max         <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign adv_s2    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s2;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// first stage: terms and loop state
	pidc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (accept),
		.setpoint    (req.setpoint),
		.measurement (req.measurement),
		.cfg         (cfg_q),
		.terms       (terms)
	);

	// second stage: sum, round half up, clamp high then low
	always_comb begin
		sum      = SumW'(terms.prop) + SumW'(terms.integ) + SumW'(terms.deriv)
			+ (SumW'(1) <<< (pidc_pkg::FracW - 1));
		eff_full = EffW'(sum >>> pidc_pkg::FracW);
		eff_hi   = (eff_full > EffW'(cfg_q.effort_max)) ? EffW'(cfg_q.effort_max) : eff_full;
		effort   = (eff_hi < EffW'(cfg_q.effort_min)) ? cfg_q.effort_min
			: pidc_pkg::SampleW'(eff_hi);
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			effort_q <= effort;
			drive_q  <= pidc_pkg::DriveW'(terms.meas) + pidc_pkg::DriveW'(effort);
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.control_effort = effort_q;
	assign rsp.drive_position = drive_q;

	// checks
	`PIDC_ASSERT_NXT(a_s1_hold, valid_s1 && !adv_s2, valid_s1, "stage one dropped a stalled item")
	`PIDC_ASSERT_NXT(a_accept_fill, accept, valid_s1, "accepted item did not reach stage one")
	`PIDC_ASSERT_NOW(a_effort_range, out_valid_q && (cfg_q.effort_min <= cfg_q.effort_max), (effort_q >= cfg_q.effort_min) && (effort_q <= cfg_q.effort_max), "effort outside its limits")
	`PIDC_ASSERT_NOW(a_no_overrun, valid_s1 && out_valid_q && !rsp.ready, !req.ready, "input taken with both stages full")

endmodule
